// ===== src/ntpr_pkg.sv =====
// Shared types and constants for the note to pitch ratio unit.
package ntpr_pkg;

  localparam int PITCH_ENTRIES = 64;
  localparam int NAME_ENTRIES  = 16;
  localparam int PITCH_AW      = $clog2(PITCH_ENTRIES);
  localparam int NAME_AW       = $clog2(NAME_ENTRIES);

  // Divider works on the 9 bit magnitude of the integer rank.
  localparam int DIV_STEPS = 9;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [6:0]  PITCH_CLASSES_RST = 7'd12;
  localparam logic [22:0] REPEAT_RATIO_RST  = 23'd65536;
  localparam logic [23:0] STD_PITCH_RST     = 24'd0;

  localparam logic signed [36:0] SAT_MAX = 37'sd8388607;
  localparam logic signed [36:0] SAT_MIN = -37'sd8388608;

  typedef enum logic [1:0] {
    CMD_CONVERT  = 2'd0,
    CMD_PITCH_WR = 2'd1,
    CMD_RANK_WR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PITCH_CLASSES = 2'd0,
    REG_REPEAT_RATIO  = 2'd1,
    REG_STD_PITCH     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_DIV,
    ST_FIX,
    ST_MUL,
    ST_RD2,
    ST_INTP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic wr_pitch;
    logic wr_rank;
    logic capture;
    logic load_div;
    logic div_step;
    logic fix;
    logic mul;
    logic rd2;
    logic intp;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// ===== src/ntpr_ctrl.sv =====
// Sequencer for the note to pitch ratio unit.
module ntpr_ctrl
  import ntpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  dp_status_t sts,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (in_command)
            CMD_CONVERT: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_RANK;
            end
            CMD_PITCH_WR: cmd.wr_pitch = 1'b1;
            CMD_RANK_WR:  cmd.wr_rank  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RANK: begin
        cmd.load_div = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = ST_INTP;
      end
      ST_INTP: begin
        cmd.intp  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/ntpr_datapath.sv =====
// Datapath of the note to pitch ratio unit: tables, divider, multipliers.
module ntpr_datapath
  import ntpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_status_t         sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [5:0]         in_entry_index,
  input  logic signed [15:0] in_accidental,
  input  logic signed [5:0]  in_octave,
  input  logic signed [23:0] in_table_value,
  output logic               out_valid,
  output logic signed [23:0] out_log2_multiplier
);

  // config
  logic [6:0]         pitch_classes_r;
  logic [22:0]        repeat_ratio_r;
  logic signed [23:0] std_pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_classes_r <= PITCH_CLASSES_RST;
      repeat_ratio_r  <= REPEAT_RATIO_RST;
      std_pitch_r     <= STD_PITCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PITCH_CLASSES: pitch_classes_r <= cfg_data[6:0];
        REG_REPEAT_RATIO:  repeat_ratio_r  <= cfg_data[22:0];
        REG_STD_PITCH:     std_pitch_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective pitch class count, clamped to 1..PITCH_ENTRIES
  logic [6:0] p_eff;
  always_comb begin
    if (pitch_classes_r == 7'd0) begin
      p_eff = 7'd1;
    end else if (pitch_classes_r > 7'(PITCH_ENTRIES)) begin
      p_eff = 7'(PITCH_ENTRIES);
    end else begin
      p_eff = pitch_classes_r;
    end
  end

  // tables
  logic signed [23:0] pitch_mem [PITCH_ENTRIES];
  logic [14:0]        rank_mem  [NAME_ENTRIES];
  logic signed [23:0] pitch_rd_r;
  logic [14:0]        rank_rd_r;
  logic [PITCH_AW-1:0] pitch_raddr;
  logic               pitch_ok, name_ok;

  assign pitch_ok = {1'b0, in_entry_index} < 7'(PITCH_ENTRIES);
  assign name_ok  = {1'b0, in_entry_index} < 7'(NAME_ENTRIES);

  always_ff @(posedge clk) begin
    if (cmd.wr_pitch && pitch_ok) begin
      pitch_mem[in_entry_index[PITCH_AW-1:0]] <= in_table_value;
    end
    pitch_rd_r <= pitch_mem[pitch_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_rank && name_ok) begin
      rank_mem[in_entry_index[NAME_AW-1:0]] <= in_table_value[14:0];
    end
    if (cmd.capture) begin
      rank_rd_r <= rank_mem[in_entry_index[NAME_AW-1:0]];
    end
  end

  // captured note
  logic signed [15:0] acc_r;
  logic signed [5:0]  oct_r;
  logic               name_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_r     <= in_accidental;
      oct_r     <= in_octave;
      name_ok_r <= name_ok;
    end
  end

  // rank = accidental + table rank, Q9.8, 18 bit signed
  logic signed [17:0] rank_sum;
  assign rank_sum = {{2{acc_r[15]}}, acc_r} + {3'b000, name_ok_r ? rank_rd_r : 15'd0};

  // restoring divider on the integer rank; negative ranks use the
  // one's complement so that floor division falls out directly
  logic [8:0]        dvd_r;
  logic [5:0]        rem_r;
  logic [7:0]        frac_r;
  logic              neg_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [6:0]        trial, rem_nxt;
  logic              ge;

  assign trial   = {rem_r, dvd_r[8]};
  assign ge      = trial >= p_eff;
  assign rem_nxt = ge ? trial - p_eff : trial;
  assign sts.div_last = cnt_r == DIV_CW'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      neg_r  <= rank_sum[17];
      dvd_r  <= rank_sum[17] ? ~rank_sum[16:8] : rank_sum[16:8];
      frac_r <= rank_sum[7:0];
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[7:0], ge};
      rem_r <= rem_nxt[5:0];
      cnt_r <= cnt_r + DIV_CW'(1);
    end
  end

  // fold quotient into octave, pick pitch indices
  logic signed [9:0]  q_fl;
  logic [6:0]         r_fl;
  logic signed [10:0] oct_eff_r;
  logic [5:0]         ip_r, next_r;
  logic               wrap_r;

  assign q_fl = neg_r ? ~{1'b0, dvd_r} : {1'b0, dvd_r};
  assign r_fl = neg_r ? p_eff - 7'd1 - {1'b0, rem_r} : {1'b0, rem_r};

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      oct_eff_r <= {{5{oct_r[5]}}, oct_r} + {q_fl[9], q_fl};
      ip_r      <= r_fl[5:0];
      wrap_r    <= r_fl == p_eff - 7'd1;
      next_r    <= (r_fl == p_eff - 7'd1) ? 6'd0 : r_fl[5:0] + 6'd1;
    end
  end

  assign pitch_raddr = cmd.rd2 ? next_r : ip_r;

  // octave level, neighbor fetch, interpolation
  logic signed [23:0] ratio_s;
  logic signed [34:0] base_r;
  logic signed [23:0] t_lo_r;
  logic signed [35:0] below_r;
  logic signed [25:0] diff;
  logic signed [8:0]  frac_s;
  logic signed [34:0] prod_r;

  assign ratio_s = {1'b0, repeat_ratio_r};
  assign frac_s  = {1'b0, frac_r};
  // wrap to entry 0 of the next octave adds one repeat ratio
  assign diff = {{2{pitch_rd_r[23]}}, pitch_rd_r} - {{2{t_lo_r[23]}}, t_lo_r}
              + (wrap_r ? {3'b000, repeat_ratio_r} : 26'sd0);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      base_r <= oct_eff_r * ratio_s;
    end
    if (cmd.rd2) begin
      t_lo_r <= pitch_rd_r;
    end
    if (cmd.intp) begin
      below_r <= {base_r[34], base_r} + {{12{t_lo_r[23]}}, t_lo_r};
      prod_r  <= diff * frac_s;
    end
  end

  // round half up, subtract standard pitch, saturate
  logic signed [34:0] prod_rnd;
  logic signed [26:0] adj;
  logic signed [36:0] res;

  assign prod_rnd = prod_r + 35'sd128;
  assign adj      = prod_rnd[34:8];
  assign res      = {below_r[35], below_r} + {{10{adj[26]}}, adj}
                  - {{13{std_pitch_r[23]}}, std_pitch_r};

  logic               out_valid_r;
  logic signed [23:0] out_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (res > SAT_MAX) begin
        out_val_r <= SAT_MAX[23:0];
      end else if (res < SAT_MIN) begin
        out_val_r <= SAT_MIN[23:0];
      end else begin
        out_val_r <= res[23:0];
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_log2_multiplier = out_val_r;

endmodule

// ===== src/note_to_pitch_ratio_unit.sv =====
// Top level of the note to pitch ratio unit.
//
// Turns a note (name index, accidental, octave) into log2 of its frequency
// multiplier, Q7.16, relative to the standard pitch, saturated to 24 bits.
// Input channel: a command word is taken at a clock edge with start high and
// busy low. Command convert produces one result; pitch table and note rank
// table writes produce none and leave busy low.
// Result channel: out_valid is high for exactly one cycle with the word on
// out_log2_multiplier; the receiver cannot stall it.
// Sequence: a convert is accepted, then the unit stays busy through rank add,
// 9 divider steps, octave fold, multiply, two table reads, interpolation
// multiply and output. out_valid shows in the cycle in which busy drops, and
// a new convert can be accepted in that same cycle; the divider is bit-serial
// floor division by the pitch class count.
// Config port: cfg_we/cfg_index/cfg_data write a register at once; write only
// while idle.
// Reset (rst_n low, synchronous): config registers take their defaults, the
// sequencer goes idle, out_valid clears. Tables are not cleared: write them
// before converting.
module note_to_pitch_ratio_unit
  import ntpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [5:0]         in_entry_index,
  input  logic signed [15:0] in_accidental,
  input  logic signed [5:0]  in_octave,
  input  logic signed [23:0] in_table_value,
  output logic               out_valid,
  output logic signed [23:0] out_log2_multiplier,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  ntpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  ntpr_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_entry_index      (in_entry_index),
    .in_accidental       (in_accidental),
    .in_octave           (in_octave),
    .in_table_value      (in_table_value),
    .out_valid           (out_valid),
    .out_log2_multiplier (out_log2_multiplier)
  );

endmodule

// ===== src/ntpr_checker.sv =====
// Port-level checks for the note to pitch ratio unit, bound to the top level.
module ntpr_checker
  import ntpr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_command,
  input logic       out_valid
);

  // a result word only shows once the unit is done
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // result strobe lasts one cycle
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // convert keeps the unit busy
  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_CONVERT) |=> busy)
    else $error("convert accepted but unit not busy");

  // table writes finish in the accepting cycle
  a_wr_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command != CMD_CONVERT) |=> !busy && !out_valid)
    else $error("write command made the unit busy or gave a result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("unit not idle after reset");

endmodule

bind note_to_pitch_ratio_unit ntpr_checker u_ntpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);
